// ===== rtl/core/word_shift_keystream_cipher_macros.svh =====
// -----------------------------------------------------------------------------
// word_shift_keystream_cipher_macros.svh
// Assertion macros for the word shift keystream cipher.
// -----------------------------------------------------------------------------
`ifndef WORD_SHIFT_KEYSTREAM_CIPHER_MACROS_SVH
`define WORD_SHIFT_KEYSTREAM_CIPHER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define WSK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define WSK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wsk_pkg.sv =====
// -----------------------------------------------------------------------------
// wsk_pkg
// Shared types and constants of the word shift keystream cipher.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsk_pkg;

  localparam int unsigned WordCount = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned PosW      = 3;

  typedef logic [WordW-1:0] word_t;

  // Transaction modes
  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_ABSORB  = 2'd1;
  localparam logic [1:0] MODE_CRYPT   = 2'd2;

  // Seed words loaded on restart and reset
  localparam word_t SEED_WORDS [WordCount] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Per-cell controls
  typedef struct packed {
    logic load;    // reload the seed word
    logic shift;   // take the neighbor word
    logic absorb;  // mix the key byte into this word
  } cell_ctrl_t;

endpackage

// ===== rtl/core/wsk_cell.sv =====
// -----------------------------------------------------------------------------
// wsk_cell
// One state word of the cipher: reload, shift from neighbor, or key absorb.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsk_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsk_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          key_i,
  input  wsk_pkg::word_t      nbr_a_i,   // word three places up
  input  wsk_pkg::word_t      nbr_b_i,   // word five places up
  input  wsk_pkg::word_t      shift_i,   // word handed down by the neighbor
  output wsk_pkg::word_t      word_o
);

  localparam wsk_pkg::word_t SeedWord = wsk_pkg::SEED_WORDS[CELL_IDX];

  wsk_pkg::word_t word_q, word_d;
  wsk_pkg::word_t mix_sum;
  wsk_pkg::word_t mixed;

  // Form the absorb sum, xor it in, rotate left by 7
  always_comb begin
    mix_sum = {24'd0, key_i} + {nbr_a_i[26:0], 5'd0} + {2'd0, nbr_b_i[31:2]};
    mixed   = word_q ^ mix_sum;
  end

  // Select the next word
  always_comb begin
    priority if (ctrl_i.load) begin
      word_d = SeedWord;
    end else if (ctrl_i.shift) begin
      word_d = shift_i;
    end else if (ctrl_i.absorb) begin
      word_d = {mixed[24:0], mixed[31:25]};
    end else begin
      word_d = word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= SeedWord;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/wsk_keygen.sv =====
// -----------------------------------------------------------------------------
// wsk_keygen
// Xorshift of words 0, 3 and 5 into the next keystream word.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsk_keygen (
  input  wsk_pkg::word_t w0_i,
  input  wsk_pkg::word_t w3_i,
  input  wsk_pkg::word_t w5_i,
  output wsk_pkg::word_t key_word_o
);

  wsk_pkg::word_t x0, x1, x2;

  // Apply the three xorshift steps
  always_comb begin
    x0         = w0_i ^ w3_i ^ w5_i;
    x1         = x0 ^ {x0[18:0], 13'd0};
    x2         = x1 ^ {17'd0, x1[31:17]};
    key_word_o = x2 ^ {x2[26:0], 5'd0};
  end

endmodule

// ===== rtl/core/word_shift_keystream_cipher.sv =====
// -----------------------------------------------------------------------------
// word_shift_keystream_cipher
// Byte stream cipher on a row of eight 32-bit word cells with key absorb.
// -----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o  | mode_i, data_byte_i
//  out     | output    | out_valid_o / out_ready_i| out_byte_o
//
//  One transaction per cycle while in_ready_o is high: every mode finishes in the cycle it is taken.
//  A crypt result sits in the output register from the cycle after it is taken.
//  in_ready_o drops only while a result waits and out_ready_i is low.
//  Reset loads the seed words and clears the absorb position at once.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "word_shift_keystream_cipher_macros.svh"

module word_shift_keystream_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o
);

  localparam int unsigned N = wsk_pkg::WordCount;

  logic                          in_acc;
  logic                          do_restart, do_absorb, do_crypt;
  logic [wsk_pkg::PosW-1:0]      pos_q, pos_d;
  wsk_pkg::word_t                word_w [N];
  wsk_pkg::word_t                key_word;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    out_byte_q, out_byte_d;

  // Decode the accepted transaction
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign do_restart = in_acc && (mode_i == wsk_pkg::MODE_RESTART);
  assign do_absorb  = in_acc && (mode_i == wsk_pkg::MODE_ABSORB);
  assign do_crypt   = in_acc && (mode_i == wsk_pkg::MODE_CRYPT);

  // Next keystream word from the current row
  wsk_keygen u_keygen (
    .w0_i       (word_w[0]),
    .w3_i       (word_w[3]),
    .w5_i       (word_w[5]),
    .key_word_o (key_word)
  );

  // Row of word cells; each hands its word down on crypt
  for (genvar i = 0; i < N; i++) begin : g_cell
    wsk_pkg::cell_ctrl_t ctrl;
    wsk_pkg::word_t      shift_in;

    assign ctrl.load   = do_restart;
    assign ctrl.shift  = do_crypt;
    assign ctrl.absorb = do_absorb && (pos_q == wsk_pkg::PosW'(i));

    if (i == N - 1) begin : g_tail
      assign shift_in = key_word;
    end else begin : g_body
      assign shift_in = word_w[i+1];
    end

    wsk_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .key_i   (data_byte_i),
      .nbr_a_i (word_w[(i+3)%N]),
      .nbr_b_i (word_w[(i+5)%N]),
      .shift_i (shift_in),
      .word_o  (word_w[i])
    );
  end

  // Advance or clear the absorb position
  always_comb begin
    priority if (do_restart) begin
      pos_d = '0;
    end else if (do_absorb) begin
      pos_d = pos_q + wsk_pkg::PosW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // Hold, load or drop the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    if (do_crypt) begin
      out_valid_d = 1'b1;
      out_byte_d  = data_byte_i ^ key_word[7:0];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // Assertions
  `WSK_ASSERT_NOW(a_result_from_crypt, clk_i, rst_ni, $rose(out_valid_q), $past(do_crypt), "result without crypt transaction")
  `WSK_ASSERT_NEXT(a_restart_clears_pos, clk_i, rst_ni, do_restart, pos_q == '0, "restart did not clear absorb position")
  `WSK_ASSERT_NEXT(a_absorb_advances_pos, clk_i, rst_ni, do_absorb, pos_q == wsk_pkg::PosW'($past(pos_q) + 1'b1), "absorb did not advance position")
  `WSK_ASSERT_NEXT(a_crypt_appends_word, clk_i, rst_ni, do_crypt, word_w[N-1] == $past(key_word), "crypt did not append keystream word")

endmodule

// ===== bench/tb_word_shift_keystream_cipher.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_word_shift_keystream_cipher
// Self-checking bench for the word shift keystream cipher.
//
// Drives restart, absorb, crypt and unused-mode transactions through the input
// channel. A cycle-free model of the eight mixing words and the absorb position
// predicts the output byte of every crypt. Each output transaction is compared
// with the oldest prediction. Directed corner cases come first, then random key
// sessions under several sender and receiver idling profiles.
// -----------------------------------------------------------------------------

module tb_word_shift_keystream_cipher;

  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned DrainCycles   = 8;

  localparam logic [31:0] KS_SEED [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] mode_i      = wsk_pkg::MODE_RESTART;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;

  // Keystream model state
  logic [31:0] ks_words [8];
  logic [2:0]  ks_absorb_pos;

  logic [7:0]  crypt_bytes_q [$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned recv_stall_pct = 0;

  word_shift_keystream_cipher uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Load the seed words into the model
  task automatic seed_keystream();
    for (int i = 0; i < 8; i++) ks_words[i] = KS_SEED[i];
    ks_absorb_pos = '0;
  endtask

  // Advance the model by one transaction; report the crypt byte if any
  task automatic advance_keystream(input logic [1:0] mode, input logic [7:0] data,
                                   output bit has_byte, output logic [7:0] crypt_byte);
    logic [2:0]  pos;
    logic [2:0]  idx_a;
    logic [2:0]  idx_b;
    logic [31:0] sum;
    logic [31:0] w;
    logic [31:0] x;
    has_byte   = 1'b0;
    crypt_byte = 8'h00;
    case (mode)
      wsk_pkg::MODE_RESTART: begin
        seed_keystream();
      end
      wsk_pkg::MODE_ABSORB: begin
        pos   = ks_absorb_pos;
        idx_a = pos + 3'd3;
        idx_b = pos + 3'd5;
        sum   = {24'h0, data} + (ks_words[idx_a] << 5) + (ks_words[idx_b] >> 2);
        w     = ks_words[pos] ^ sum;
        ks_words[pos] = {w[24:0], w[31:25]};
        ks_absorb_pos = pos + 3'd1;
      end
      wsk_pkg::MODE_CRYPT: begin
        x = ks_words[0] ^ ks_words[3] ^ ks_words[5];
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        for (int i = 0; i < 7; i++) ks_words[i] = ks_words[i+1];
        ks_words[7] = x;
        has_byte   = 1'b1;
        crypt_byte = data ^ x[7:0];
      end
      default: begin
      end
    endcase
  endtask

  // Check output transactions, predict input transactions, watch for hangs
  always @(posedge clk_i) begin
    bit         has_byte;
    logic [7:0] crypt_byte;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (crypt_bytes_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("[%0t] unexpected output byte 0x%02h", $time, out_byte_o);
        end else begin
          crypt_byte = crypt_bytes_q.pop_front();
          if (out_byte_o !== crypt_byte) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
              $display("[%0t] out_byte mismatch: expected 0x%02h, actual 0x%02h",
                       $time, crypt_byte, out_byte_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        advance_keystream(mode_i, data_byte_i, has_byte, crypt_byte);
        if (has_byte) crypt_bytes_q.push_back(crypt_byte);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("[%0t] no transaction for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Drop out_ready at random per the current stall rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] mode, input logic [7:0] data,
                           input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Restart-absorb-crypt sessions mixed with stray transactions
  task automatic run_sessions(input int unsigned send_pct, input int unsigned recv_pct,
                              input int unsigned item_goal);
    int unsigned done_items;
    int unsigned n_absorb;
    int unsigned n_crypt;
    logic [1:0]  mode;
    done_items     = 0;
    recv_stall_pct = recv_pct;
    while (done_items < item_goal) begin
      if ($urandom_range(99) < 80) begin
        send_item(wsk_pkg::MODE_RESTART, 8'($urandom_range(255)), send_pct);
        n_absorb = $urandom_range(16);
        n_crypt  = $urandom_range(16, 1);
        repeat (n_absorb)
          send_item(wsk_pkg::MODE_ABSORB, 8'($urandom_range(255)), send_pct);
        // key derivation crypts zero bytes, data crypts arbitrary bytes
        repeat (n_crypt)
          send_item(wsk_pkg::MODE_CRYPT,
                    ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)),
                    send_pct);
        done_items += 1 + n_absorb + n_crypt;
      end else begin
        mode = 2'($urandom_range(3));
        send_item(mode, 8'($urandom_range(255)), send_pct);
        if (mode != MODE_UNUSED) done_items++;
      end
    end
  endtask

  // Corner cases: crypt from the reset words, unused mode, absorb wrap
  task automatic test_directed_cases();
    recv_stall_pct = 0;
    send_item(wsk_pkg::MODE_CRYPT,  8'h00, 0);
    send_item(wsk_pkg::MODE_CRYPT,  8'hff, 0);
    send_item(MODE_UNUSED, 8'hff, 0);
    send_item(MODE_UNUSED, 8'h00, 0);
    send_item(wsk_pkg::MODE_ABSORB, 8'hff, 0);
    send_item(wsk_pkg::MODE_CRYPT,  8'ha5, 0);
    send_item(wsk_pkg::MODE_ABSORB, 8'h00, 0);
    send_item(wsk_pkg::MODE_RESTART, 8'h5a, 0);
    repeat (9) send_item(wsk_pkg::MODE_ABSORB, 8'hff, 0);
    send_item(wsk_pkg::MODE_CRYPT,  8'h00, 0);
    send_item(wsk_pkg::MODE_CRYPT,  8'hff, 0);
    send_item(wsk_pkg::MODE_RESTART, 8'hff, 0);
    send_item(wsk_pkg::MODE_CRYPT,  8'h80, 0);
  endtask

  task automatic test_back_to_back();
    run_sessions(0, 0, 420);
  endtask

  task automatic test_sender_gaps();
    run_sessions(65, 0, 400);
  endtask

  task automatic test_receiver_stalls();
    run_sessions(0, 65, 400);
  endtask

  task automatic test_mixed_gaps();
    run_sessions(20, 20, 400);
  endtask

  initial begin
    seed_keystream();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();

    // Drain outstanding crypt bytes, then wait for stray output
    in_valid_i <= 1'b0;
    while (crypt_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && crypt_bytes_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
